// ===== rtl/bccm_pkg.sv =====
// Shared types, register indexes and constants of the box-counting color mask block.
package bccm_pkg;

  localparam int DIM_W = 7;
  localparam int DIAM_W = 5;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 13;
  localparam int EXTENT_W = 6;
  localparam int AREA_W = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_DATA_W = 48;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_DIAMETERS = 16;
  localparam int DIAM_LIMIT = (MAX_DIAMETERS > 16) ? 16 : MAX_DIAMETERS;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLOR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIAMETER = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_COLUMNS = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS = 8'd3;

  localparam logic [COLOR_W-1:0] TARGET_RESET = 24'd0;
  localparam logic [DIAM_W-1:0] MAX_DIAMETER_RESET = 5'd16;
  localparam logic [DIM_W-1:0] COLUMNS_RESET = 7'd64;
  localparam logic [DIM_W-1:0] ROWS_RESET = 7'd64;

  // Effective configuration, already clamped to the legal ranges.
  typedef struct packed {
    logic [COLOR_W-1:0] target_color;
    logic [DIM_W-1:0]   columns;
    logic [DIM_W-1:0]   rows;
    logic [DIAM_W-1:0]  diameters;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic scan;
    logic next_pass;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic busy;
    logic out_full;
    logic diam_last;
  } dp_status_t;

endpackage

// ===== rtl/bccm_regs.sv =====
// Configuration registers with range clamping of the image geometry and diameter count.
module bccm_regs
  import bccm_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [COLOR_W-1:0] target_color;
  logic [DIAM_W-1:0]  max_diameter;
  logic [DIM_W-1:0]   image_columns;
  logic [DIM_W-1:0]   image_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color <= TARGET_RESET;
      max_diameter <= MAX_DIAMETER_RESET;
      image_columns <= COLUMNS_RESET;
      image_rows <= ROWS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_COLOR: target_color <= cfg_data[COLOR_W-1:0];
        REG_MAX_DIAMETER: max_diameter <= cfg_data[DIAM_W-1:0];
        REG_IMAGE_COLUMNS: image_columns <= cfg_data[DIM_W-1:0];
        REG_IMAGE_ROWS: image_rows <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.target_color = target_color;

    if (image_columns == '0) begin
      cfg.columns = DIM_W'(1);
    end else if (32'(image_columns) > MAX_COLUMNS) begin
      cfg.columns = DIM_W'(MAX_COLUMNS);
    end else begin
      cfg.columns = image_columns;
    end

    if (image_rows == '0) begin
      cfg.rows = DIM_W'(1);
    end else if (32'(image_rows) > MAX_ROWS) begin
      cfg.rows = DIM_W'(MAX_ROWS);
    end else begin
      cfg.rows = image_rows;
    end

    if (max_diameter == '0) begin
      cfg.diameters = DIAM_W'(1);
    end else if (32'(max_diameter) > DIAM_LIMIT) begin
      cfg.diameters = DIAM_W'(DIAM_LIMIT);
    end else begin
      cfg.diameters = max_diameter;
    end
  end

endmodule

// ===== rtl/bccm_ctrl.sv =====
// Controller state machine: pixel loading, one scan pass per diameter, result hand-off.
module bccm_ctrl
  import bccm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       s_tlast,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_LOAD);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_LOAD: begin
        cmd.accept = s_tvalid;
        if (s_tvalid && s_tlast) begin
          cmd.start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_end) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // The next pass starts only once the previous result has left.
        if (!status.busy && !status.out_full) begin
          if (status.diam_last) begin
            cmd.finish = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.next_pass = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/bccm_datapath.sv =====
// Datapath: match map memory, box-order scan, box counting, bounding box and result register.
module bccm_datapath
  import bccm_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  logic [COLOR_W-1:0]  pixel_color,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [DIAM_W-1:0]   diameter,
  output logic [COUNT_W-1:0]  box_count,
  output logic                any_match,
  output logic [EXTENT_W-1:0] bbox_width,
  output logic [EXTENT_W-1:0] bbox_height,
  output logic [AREA_W-1:0]   bbox_area,
  output logic                last_result
);

  localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int POS_W = $clog2(MAP_DEPTH + 1);

  logic match_map [MAP_DEPTH];

  logic [POS_W-1:0]   pixel_position;
  logic [2*DIM_W-1:0] total;
  logic               pos_room;

  // Geometry latched when the computation starts.
  logic [DIM_W-1:0]  g_cols;
  logic [DIM_W-1:0]  g_rows;
  logic [DIAM_W-1:0] g_ndiam;
  logic [DIAM_W-1:0] diam;

  // Scan position: pixel row and column, and origin of the current box.
  logic [DIM_W-1:0] row;
  logic [DIM_W-1:0] col;
  logic [DIM_W-1:0] row0;
  logic [DIM_W-1:0] col0;

  logic [DIM_W:0]     col_inc;
  logic [DIM_W:0]     row_inc;
  logic [DIM_W:0]     col_next_box;
  logic [DIM_W:0]     row_next_box;
  logic               stay_col;
  logic               stay_row;
  logic               more_cols;
  logic               more_rows;
  logic               box_last;
  logic               pass_last;
  logic [2*DIM_W-1:0] lin;

  // Read stage.
  logic             s1_valid;
  logic             s1_inpos;
  logic             s1_box_last;
  logic             s1_pass_last;
  logic [DIM_W-1:0] s1_row;
  logic [DIM_W-1:0] s1_col;
  logic             rd_bit;

  // Accumulation stage.
  logic               hit;
  logic               box_acc;
  logic [COUNT_W-1:0] count;
  logic               found;
  logic [DIM_W-1:0]   min_col;
  logic [DIM_W-1:0]   max_col;
  logic [DIM_W-1:0]   min_row;
  logic [DIM_W-1:0]   max_row;
  logic               pend;

  logic [DIM_W-1:0]   ext_w;
  logic [DIM_W-1:0]   ext_h;
  logic [2*DIM_W-1:0] area_full;

  assign total = cfg.columns * cfg.rows;
  assign pos_room = 32'(pixel_position) < 32'(total);

  always_ff @(posedge clk) begin
    if (cmd.accept && pos_room) begin
      match_map[ADDR_W'(pixel_position)] <= (pixel_color == cfg.target_color);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
    end else if (cmd.finish) begin
      pixel_position <= '0;
    end else if (cmd.accept && pos_room) begin
      pixel_position <= pixel_position + POS_W'(1);
    end
  end

  // Boxes are walked one after another; inside a box the pixels go in raster order,
  // clipped at the right and bottom image edges.
  always_comb begin
    col_inc = {1'b0, col} + (DIM_W+1)'(1);
    row_inc = {1'b0, row} + (DIM_W+1)'(1);
    col_next_box = {1'b0, col0} + (DIM_W+1)'(diam);
    row_next_box = {1'b0, row0} + (DIM_W+1)'(diam);
    stay_col = (col_inc < col_next_box) && (col_inc < {1'b0, g_cols});
    stay_row = (row_inc < row_next_box) && (row_inc < {1'b0, g_rows});
    more_cols = col_next_box < {1'b0, g_cols};
    more_rows = row_next_box < {1'b0, g_rows};
    box_last = !stay_col && !stay_row;
    pass_last = box_last && !more_cols && !more_rows;
  end

  assign lin = row * g_cols + {{DIM_W{1'b0}}, col};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      g_cols <= cfg.columns;
      g_rows <= cfg.rows;
      g_ndiam <= cfg.diameters;
      diam <= DIAM_W'(1);
    end else if (cmd.next_pass) begin
      diam <= diam + DIAM_W'(1);
    end

    if (cmd.start || cmd.next_pass) begin
      row <= '0;
      col <= '0;
      row0 <= '0;
      col0 <= '0;
    end else if (cmd.scan) begin
      if (stay_col) begin
        col <= col_inc[DIM_W-1:0];
      end else if (stay_row) begin
        row <= row_inc[DIM_W-1:0];
        col <= col0;
      end else if (more_cols) begin
        col0 <= col_next_box[DIM_W-1:0];
        col <= col_next_box[DIM_W-1:0];
        row <= row0;
      end else if (more_rows) begin
        row0 <= row_next_box[DIM_W-1:0];
        row <= row_next_box[DIM_W-1:0];
        col0 <= '0;
        col <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_bit <= match_map[ADDR_W'(lin)];
    s1_inpos <= 32'(lin) < 32'(pixel_position);
    s1_box_last <= box_last;
    s1_pass_last <= pass_last;
    s1_row <= row;
    s1_col <= col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      s1_valid <= cmd.scan;
      pend <= s1_valid && s1_pass_last;
    end
  end

  assign hit = rd_bit && s1_inpos;

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.next_pass) begin
      count <= '0;
      box_acc <= 1'b0;
    end else if (s1_valid) begin
      if (s1_box_last) begin
        count <= count + COUNT_W'(box_acc || hit);
        box_acc <= 1'b0;
      end else begin
        box_acc <= box_acc || hit;
      end
    end
  end

  // The bounding box is gathered during the first pass, which runs in raster order.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found <= 1'b0;
      min_col <= '1;
      min_row <= '1;
      max_col <= '0;
      max_row <= '0;
    end else if (s1_valid && hit && diam == DIAM_W'(1)) begin
      found <= 1'b1;
      if (s1_col < min_col) min_col <= s1_col;
      if (s1_col > max_col) max_col <= s1_col;
      if (s1_row < min_row) min_row <= s1_row;
      if (s1_row > max_row) max_row <= s1_row;
    end
  end

  assign ext_w = found ? (max_col - min_col) : '0;
  assign ext_h = found ? (max_row - min_row) : '0;
  assign area_full = ext_w * ext_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      diameter <= diam;
      box_count <= count;
      any_match <= found;
      bbox_width <= ext_w[EXTENT_W-1:0];
      bbox_height <= ext_h[EXTENT_W-1:0];
      bbox_area <= area_full[AREA_W-1:0];
      last_result <= (diam == g_ndiam);
    end
  end

  assign status.scan_end = pass_last;
  assign status.busy = s1_valid || pend;
  assign status.out_full = out_valid;
  assign status.diam_last = (diam == g_ndiam);

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pend |-> !out_valid)
    else $error("result register loaded while still holding a result");

  a_scan_out_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !out_valid)
    else $error("scan pass running while a result waits");

  a_pass_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pass_last) |=> pend)
    else $error("end of pass did not produce a result");

  a_pass_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.next_pass |-> (!s1_valid && !pend))
    else $error("new pass started with the pipeline busy");

endmodule

// ===== rtl/box_count_color_mask.sv =====
// Top level of the box-counting color mask: configuration, controller and datapath.
// Pixels transfer at one per cycle while the controller is loading; a non-final
// pixel produces no result. After the final pixel the block runs one pass per
// diameter, reading each pixel's match bit once per pass, then drains the read
// stage and hands off the result, waiting for it to transfer before the next pass.
// Reset (synchronous) restores register defaults and clears control; no memory sweep.
module box_count_color_mask
  import bccm_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel: index selects the register, data carries the value.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Pixel stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [COLOR_W-1:0]     s_tdata,  // pixel_color[23:0]
  input  logic                   s_tlast,  // last_pixel
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // diameter[4:0], box_count[17:5], any_match[18], bbox_width[24:19],
  // bbox_height[30:25], bbox_area[42:31], zero[47:43]
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic                   m_tlast   // last_result
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [DIAM_W-1:0]   diameter;
  logic [COUNT_W-1:0]  box_count;
  logic                any_match;
  logic [EXTENT_W-1:0] bbox_width;
  logic [EXTENT_W-1:0] bbox_height;
  logic [AREA_W-1:0]   bbox_area;

  // Register file; the values handed on are clamped to the supported ranges.
  bccm_regs #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  // The controller accepts pixels only while loading. Once the last pixel
  // transfers, it steps the datapath through one scan per diameter and waits
  // for each result to transfer before it starts the next pass.
  bccm_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast(s_tlast),
    .status(status),
    .cmd(cmd)
  );

  // The datapath stores one match bit per pixel, walks the map box by box,
  // counts boxes that hold a match and keeps the bounding box from the first pass.
  bccm_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd(cmd),
    .status(status),
    .pixel_color(s_tdata),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .diameter(diameter),
    .box_count(box_count),
    .any_match(any_match),
    .bbox_width(bbox_width),
    .bbox_height(bbox_height),
    .bbox_area(bbox_area),
    .last_result(m_tlast)
  );

  // Result fields packed from the lowest bit up, padded with zeros to whole bytes.
  assign m_tdata = {5'd0, bbox_area, bbox_height, bbox_width, any_match, box_count, diameter};

endmodule
